[rtl/nfdw_pkg.sv]
// ----------------------------------------------------------------------------
// nfdw_pkg
// shared widths, codes and record types of the finite-difference weight unit
// ----------------------------------------------------------------------------
package nfdw_pkg;

   localparam int LANES        = 4;
   localparam int TIME_WIDTH   = 32;
   localparam int TIME_FRAC    = TIME_WIDTH / 2;
   localparam int WEIGHT_WIDTH = 48;
   localparam int WEIGHT_FRAC  = WEIGHT_WIDTH / 2;
   localparam int DIFF_WIDTH   = 32;
   localparam int DEN_WIDTH    = 3 * DIFF_WIDTH;
   localparam int NUM1_WIDTH   = 2 * DIFF_WIDTH + 2;
   localparam int NUM2_WIDTH   = DIFF_WIDTH + 3;
   localparam int NUM3_WIDTH   = 3;
   localparam int N_WIDTH      = NUM1_WIDTH + WEIGHT_FRAC + TIME_FRAC + 2;
   localparam int D_WIDTH      = DEN_WIDTH + 1;
   localparam int QUO_BITS     = WEIGHT_WIDTH;
   localparam int LANE_DEPTH   = QUO_BITS + 2;
   localparam int SIZE_WIDTH   = 3;
   localparam int ROW_WIDTH    = 2;

   localparam int SHIFT_D1 = WEIGHT_FRAC + TIME_FRAC + 1;
   localparam int SHIFT_D2 = WEIGHT_FRAC + 2 * TIME_FRAC + 1;
   localparam int SHIFT_D3 = WEIGHT_FRAC + 3 * TIME_FRAC + 1;

   localparam logic [SIZE_WIDTH-1:0] SIZE_TWO   = 3'd2;
   localparam logic [SIZE_WIDTH-1:0] SIZE_THREE = 3'd3;
   localparam logic [SIZE_WIDTH-1:0] SIZE_FOUR  = 3'd4;
   localparam logic [SIZE_WIDTH-1:0] SIZE_RESET = SIZE_FOUR;

   localparam logic [ROW_WIDTH-1:0] ROW_D0 = 2'd0;
   localparam logic [ROW_WIDTH-1:0] ROW_D1 = 2'd1;
   localparam logic [ROW_WIDTH-1:0] ROW_D2 = 2'd2;
   localparam logic [ROW_WIDTH-1:0] ROW_D3 = 2'd3;

   localparam logic [LANES-1:0] LANE_NEG = 4'b1010;

   localparam logic [WEIGHT_WIDTH-1:0] WEIGHT_ONE = WEIGHT_WIDTH'(1) << WEIGHT_FRAC;
   localparam logic [WEIGHT_WIDTH-1:0] WEIGHT_MAX = {1'b0, {(WEIGHT_WIDTH-1){1'b1}}};
   localparam logic [WEIGHT_WIDTH-1:0] WEIGHT_MIN = {1'b1, {(WEIGHT_WIDTH-1){1'b0}}};

   typedef struct packed {
      logic [DEN_WIDTH-1:0]  den;
      logic [NUM1_WIDTH-1:0] n1;
      logic [NUM2_WIDTH-1:0] n2;
      logic [NUM3_WIDTH-1:0] n3;
   } lane_item_type;

   typedef struct packed {
      lane_item_type [LANES-1:0] lane;
      logic [LANES-1:0]          act;
      logic                      bad;
      logic [SIZE_WIDTH-1:0]     size;
   } item_type;

   typedef struct packed {
      logic                 valid;
      logic [ROW_WIDTH-1:0] row;
      logic                 last;
      logic                 bad;
      logic [LANES-1:0]     act;
   } ctl_type;

endpackage

[rtl/nfdw_prep.sv]
// ----------------------------------------------------------------------------
// nfdw_prep
// per-item front end: time differences, order check, denominators, numerators
// ----------------------------------------------------------------------------
module nfdw_prep (
   input  logic                                                clock,
   input  logic                                                reset,
   input  logic                                                in_valid,
   output logic                                                in_ready,
   input  logic [nfdw_pkg::LANES-1:0][nfdw_pkg::TIME_WIDTH-1:0] times_i,
   input  logic [nfdw_pkg::SIZE_WIDTH-1:0]                     size_i,
   output logic                                                out_valid,
   output nfdw_pkg::item_type                                  out_item,
   input  logic                                                out_take
);

   localparam int DW = nfdw_pkg::DIFF_WIDTH;
   localparam int L  = nfdw_pkg::LANES;

   function automatic logic is_pos(input logic [DW:0] d);
      is_pos = !d[DW] && (d != '0);
   endfunction

   logic en1, en2, en3, en4, en5;
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;

   // stage 1
   logic [DW:0] d01, d12, d23, d02, d03, d13;
   logic [nfdw_pkg::SIZE_WIDTH-1:0] size_in;
   logic bad_in;
   logic [DW-1:0] a_ff, b_ff, c_ff, bb_ff, cc_ff, e_ff;
   logic [nfdw_pkg::SIZE_WIDTH-1:0] s1_size_ff, s2_size_ff, s3_size_ff, s4_size_ff;
   logic s1_bad_ff, s2_bad_ff, s3_bad_ff, s4_bad_ff;

   // stage 2
   logic [DW:0]   sum_ab, sum_bc, sum_ac;
   logic [DW+1:0] sum_abc;
   logic [DW-1:0] x_in [L];
   logic [DW-1:0] y_in [L];
   logic [DW-1:0] z_in [L];
   logic [DW-1:0] p1_in [L];
   logic [DW:0]   p2_in [L];
   logic [DW-1:0] p3_in [L];
   logic [DW:0]   p4_in [L];
   logic [nfdw_pkg::NUM2_WIDTH-1:0] n2_in [L];
   logic [nfdw_pkg::NUM3_WIDTH-1:0] n3_in [L];
   logic [L-1:0] act_in;
   logic [DW-1:0] x_ff [L];
   logic [DW-1:0] y_ff [L];
   logic [DW-1:0] z2_ff [L];
   logic [DW-1:0] p1_ff [L];
   logic [DW:0]   p2_ff [L];
   logic [DW-1:0] p3_ff [L];
   logic [DW:0]   p4_ff [L];
   logic [nfdw_pkg::NUM2_WIDTH-1:0] n2_2_ff [L];
   logic [nfdw_pkg::NUM3_WIDTH-1:0] n3_2_ff [L];
   logic [L-1:0] act2_ff;

   // stage 3
   logic [2*DW-1:0] xy_ff [L];
   logic [2*DW:0]   m1_ff [L];
   logic [2*DW:0]   m2_ff [L];
   logic [DW-1:0]   z3_ff [L];
   logic [nfdw_pkg::NUM2_WIDTH-1:0] n2_3_ff [L];
   logic [nfdw_pkg::NUM3_WIDTH-1:0] n3_3_ff [L];
   logic [L-1:0] act3_ff;

   // stage 4
   logic [2*DW-1:0] plo_ff [L];
   logic [2*DW-1:0] phi_ff [L];
   logic [nfdw_pkg::NUM1_WIDTH-1:0] n1_4_ff [L];
   logic [nfdw_pkg::NUM2_WIDTH-1:0] n2_4_ff [L];
   logic [nfdw_pkg::NUM3_WIDTH-1:0] n3_4_ff [L];
   logic [L-1:0] act4_ff;

   // stage 5
   nfdw_pkg::item_type item_ff;

   assign en5 = !v5_ff || out_take;
   assign en4 = !v4_ff || en5;
   assign en3 = !v3_ff || en4;
   assign en2 = !v2_ff || en3;
   assign en1 = !v1_ff || en2;
   assign in_ready  = en1;
   assign out_valid = v5_ff;
   assign out_item  = item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         if (en1) v1_ff <= in_valid;
         if (en2) v2_ff <= v1_ff;
         if (en3) v3_ff <= v2_ff;
         if (en4) v4_ff <= v3_ff;
         if (en5) v5_ff <= v4_ff;
      end
   end

   assign d01 = {times_i[0][DW-1], times_i[0]} - {times_i[1][DW-1], times_i[1]};
   assign d12 = {times_i[1][DW-1], times_i[1]} - {times_i[2][DW-1], times_i[2]};
   assign d23 = {times_i[2][DW-1], times_i[2]} - {times_i[3][DW-1], times_i[3]};
   assign d02 = {times_i[0][DW-1], times_i[0]} - {times_i[2][DW-1], times_i[2]};
   assign d03 = {times_i[0][DW-1], times_i[0]} - {times_i[3][DW-1], times_i[3]};
   assign d13 = {times_i[1][DW-1], times_i[1]} - {times_i[3][DW-1], times_i[3]};

   always_comb begin
      if (size_i < nfdw_pkg::SIZE_TWO) begin
         size_in = nfdw_pkg::SIZE_TWO;
      end else if (size_i > nfdw_pkg::SIZE_FOUR) begin
         size_in = nfdw_pkg::SIZE_FOUR;
      end else begin
         size_in = size_i;
      end
      bad_in = !is_pos(d01)
             || ((size_in != nfdw_pkg::SIZE_TWO) && !is_pos(d12))
             || ((size_in == nfdw_pkg::SIZE_FOUR) && !is_pos(d23));
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         a_ff       <= d01[DW-1:0];
         b_ff       <= d12[DW-1:0];
         c_ff       <= d23[DW-1:0];
         bb_ff      <= d02[DW-1:0];
         cc_ff      <= d03[DW-1:0];
         e_ff       <= d13[DW-1:0];
         s1_size_ff <= size_in;
         s1_bad_ff  <= bad_in;
      end
   end

   assign sum_ab  = {1'b0, a_ff} + {1'b0, bb_ff};
   assign sum_bc  = {1'b0, bb_ff} + {1'b0, cc_ff};
   assign sum_ac  = {1'b0, a_ff} + {1'b0, cc_ff};
   assign sum_abc = {1'b0, sum_ab} + {2'b00, cc_ff};

   always_comb begin
      for (int j = 0; j < L; j++) begin
         x_in[j]  = '0;
         y_in[j]  = '0;
         z_in[j]  = '0;
         p1_in[j] = '0;
         p2_in[j] = '0;
         p3_in[j] = '0;
         p4_in[j] = '0;
         n2_in[j] = '0;
         n3_in[j] = '0;
      end
      act_in = '0;
      case (s1_size_ff)
         nfdw_pkg::SIZE_FOUR: begin
            x_in[0] = a_ff;   y_in[0] = bb_ff; z_in[0] = cc_ff;
            x_in[1] = a_ff;   y_in[1] = b_ff;  z_in[1] = e_ff;
            x_in[2] = bb_ff;  y_in[2] = b_ff;  z_in[2] = c_ff;
            x_in[3] = cc_ff;  y_in[3] = e_ff;  z_in[3] = c_ff;
            p1_in[0] = bb_ff; p2_in[0] = {1'b0, cc_ff};
            p3_in[0] = a_ff;  p4_in[0] = sum_bc;
            p1_in[1] = bb_ff; p2_in[1] = {1'b0, cc_ff};
            p1_in[2] = a_ff;  p2_in[2] = {1'b0, cc_ff};
            p1_in[3] = a_ff;  p2_in[3] = {1'b0, bb_ff};
            n2_in[0] = {sum_abc, 1'b0};
            n2_in[1] = {1'b0, sum_bc, 1'b0};
            n2_in[2] = {1'b0, sum_ac, 1'b0};
            n2_in[3] = {1'b0, sum_ab, 1'b0};
            for (int j = 0; j < L; j++) begin
               n3_in[j] = 3'd6;
            end
            act_in = 4'b1111;
         end
         nfdw_pkg::SIZE_THREE: begin
            x_in[0] = a_ff;  y_in[0] = bb_ff; z_in[0] = DW'(1);
            x_in[1] = a_ff;  y_in[1] = b_ff;  z_in[1] = DW'(1);
            x_in[2] = b_ff;  y_in[2] = bb_ff; z_in[2] = DW'(1);
            p1_in[0] = DW'(1); p2_in[0] = sum_ab;
            p1_in[1] = DW'(1); p2_in[1] = {1'b0, bb_ff};
            p1_in[2] = DW'(1); p2_in[2] = {1'b0, a_ff};
            for (int j = 0; j < 3; j++) begin
               n2_in[j] = nfdw_pkg::NUM2_WIDTH'(2);
            end
            act_in = 4'b0111;
         end
         nfdw_pkg::SIZE_TWO: begin
            for (int j = 0; j < 2; j++) begin
               x_in[j]  = a_ff;
               y_in[j]  = DW'(1);
               z_in[j]  = DW'(1);
               p1_in[j] = DW'(1);
               p2_in[j] = (DW+1)'(1);
            end
            act_in = 4'b0011;
         end
         default: begin
            act_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (en2) begin
         for (int j = 0; j < L; j++) begin
            x_ff[j]    <= x_in[j];
            y_ff[j]    <= y_in[j];
            z2_ff[j]   <= z_in[j];
            p1_ff[j]   <= p1_in[j];
            p2_ff[j]   <= p2_in[j];
            p3_ff[j]   <= p3_in[j];
            p4_ff[j]   <= p4_in[j];
            n2_2_ff[j] <= n2_in[j];
            n3_2_ff[j] <= n3_in[j];
         end
         act2_ff    <= act_in;
         s2_size_ff <= s1_size_ff;
         s2_bad_ff  <= s1_bad_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en3) begin
         for (int j = 0; j < L; j++) begin
            xy_ff[j]   <= (2*DW)'(x_ff[j]) * (2*DW)'(y_ff[j]);
            m1_ff[j]   <= (2*DW+1)'(p1_ff[j]) * (2*DW+1)'(p2_ff[j]);
            m2_ff[j]   <= (2*DW+1)'(p3_ff[j]) * (2*DW+1)'(p4_ff[j]);
            z3_ff[j]   <= z2_ff[j];
            n2_3_ff[j] <= n2_2_ff[j];
            n3_3_ff[j] <= n3_2_ff[j];
         end
         act3_ff    <= act2_ff;
         s3_size_ff <= s2_size_ff;
         s3_bad_ff  <= s2_bad_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en4) begin
         for (int j = 0; j < L; j++) begin
            plo_ff[j]  <= (2*DW)'(xy_ff[j][DW-1:0]) * (2*DW)'(z3_ff[j]);
            phi_ff[j]  <= (2*DW)'(xy_ff[j][2*DW-1:DW]) * (2*DW)'(z3_ff[j]);
            n1_4_ff[j] <= {1'b0, m1_ff[j]} + {1'b0, m2_ff[j]};
            n2_4_ff[j] <= n2_3_ff[j];
            n3_4_ff[j] <= n3_3_ff[j];
         end
         act4_ff    <= act3_ff;
         s4_size_ff <= s3_size_ff;
         s4_bad_ff  <= s3_bad_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en5) begin
         for (int j = 0; j < L; j++) begin
            item_ff.lane[j].den <= {{DW{1'b0}}, plo_ff[j]} + {phi_ff[j], {DW{1'b0}}};
            item_ff.lane[j].n1  <= n1_4_ff[j];
            item_ff.lane[j].n2  <= n2_4_ff[j];
            item_ff.lane[j].n3  <= n3_4_ff[j];
         end
         item_ff.act  <= act4_ff;
         item_ff.bad  <= s4_bad_ff;
         item_ff.size <= s4_size_ff;
      end
   end

endmodule

[rtl/nfdw_lane.sv]
// ----------------------------------------------------------------------------
// nfdw_lane
// one weight lane: scaled rounding divide, one quotient bit per stage
// ----------------------------------------------------------------------------
module nfdw_lane (
   input  logic                                clock,
   input  logic                                enable,
   input  logic [nfdw_pkg::DEN_WIDTH-1:0]      den_i,
   input  logic [nfdw_pkg::NUM1_WIDTH-1:0]     num_i,
   input  logic [nfdw_pkg::ROW_WIDTH-1:0]      row_i,
   output logic [nfdw_pkg::QUO_BITS-1:0]       q_o,
   output logic                                ovf_o
);

   localparam int NW = nfdw_pkg::N_WIDTH;
   localparam int DW = nfdw_pkg::D_WIDTH;
   localparam int QB = nfdw_pkg::QUO_BITS;

   logic [NW-1:0] shifted;
   logic [NW-1:0] n_in;
   logic [NW-1:0] n_ff;
   logic [DW-1:0] da_ff;
   logic [DW-1:0] top_part;

   logic [DW-1:0] rem_ff [0:QB-1];
   logic [DW-1:0] d_ff   [0:QB-1];
   logic [QB-1:0] nlo_ff [0:QB-1];
   logic [QB-1:0] q_ff   [1:QB];
   logic          ovf_ff [0:QB];

   always_comb begin
      case (row_i)
         nfdw_pkg::ROW_D1: shifted = NW'(num_i) << nfdw_pkg::SHIFT_D1;
         nfdw_pkg::ROW_D2: shifted = NW'(num_i) << nfdw_pkg::SHIFT_D2;
         nfdw_pkg::ROW_D3: shifted = NW'(num_i) << nfdw_pkg::SHIFT_D3;
         default:          shifted = '0;
      endcase
      n_in = shifted + NW'(den_i);
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         n_ff  <= n_in;
         da_ff <= {den_i, 1'b0};
      end
   end

   assign top_part = DW'(n_ff[NW-1:QB]);

   always_ff @(posedge clock) begin
      if (enable) begin
         rem_ff[0] <= top_part;
         d_ff[0]   <= da_ff;
         nlo_ff[0] <= n_ff[QB-1:0];
         ovf_ff[0] <= (top_part >= da_ff);
      end
   end

   for (genvar i = 0; i < QB; i++) begin : g_bit
      logic [DW:0] rem_sh;
      logic [DW:0] rem_sub;
      logic        ge;

      assign rem_sh  = {rem_ff[i], nlo_ff[i][QB-1]};
      assign rem_sub = rem_sh - {1'b0, d_ff[i]};
      assign ge      = (rem_sh >= {1'b0, d_ff[i]});

      always_ff @(posedge clock) begin
         if (enable) begin
            ovf_ff[i+1] <= ovf_ff[i];
         end
      end

      if (i == 0) begin : g_first
         always_ff @(posedge clock) begin
            if (enable) begin
               q_ff[1] <= {{(QB-1){1'b0}}, ge};
            end
         end
      end else begin : g_next
         always_ff @(posedge clock) begin
            if (enable) begin
               q_ff[i+1] <= {q_ff[i][QB-2:0], ge};
            end
         end
      end

      if (i < QB - 1) begin : g_carry
         always_ff @(posedge clock) begin
            if (enable) begin
               rem_ff[i+1] <= ge ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
               d_ff[i+1]   <= d_ff[i];
               nlo_ff[i+1] <= {nlo_ff[i][QB-2:0], 1'b0};
            end
         end
      end
   end

   assign q_o   = q_ff[QB];
   assign ovf_o = ovf_ff[QB];

endmodule

[rtl/nfdw_merge.sv]
// ----------------------------------------------------------------------------
// nfdw_merge
// combines lane quotients into a weight row: sign, saturation, output register
// ----------------------------------------------------------------------------
module nfdw_merge (
   input  logic                                                clock,
   input  logic                                                reset,
   input  nfdw_pkg::ctl_type                                   ctl_i,
   input  logic [nfdw_pkg::LANES-1:0][nfdw_pkg::QUO_BITS-1:0]  q_i,
   input  logic [nfdw_pkg::LANES-1:0]                          ovf_i,
   output logic                                                advance_o,
   output logic                                                rsp_tvalid,
   input  logic                                                rsp_tready,
   output logic [nfdw_pkg::LANES*nfdw_pkg::WEIGHT_WIDTH-1:0]   rsp_tdata,
   output logic [nfdw_pkg::ROW_WIDTH:0]                        rsp_tuser,
   output logic                                                rsp_tlast
);

   localparam int WW = nfdw_pkg::WEIGHT_WIDTH;

   logic [nfdw_pkg::LANES-1:0][WW-1:0] weight_in;
   logic                                valid_ff;
   logic [nfdw_pkg::LANES*WW-1:0]       data_ff;
   logic [nfdw_pkg::ROW_WIDTH:0]        user_ff;
   logic                                last_ff;

   assign advance_o = !valid_ff || rsp_tready;

   always_comb begin
      for (int j = 0; j < nfdw_pkg::LANES; j++) begin
         logic sat_pos;
         logic sat_neg;
         logic [WW-1:0] w;
         sat_pos = ovf_i[j] || q_i[j][WW-1];
         sat_neg = ovf_i[j] || (q_i[j][WW-1] && (q_i[j][WW-2:0] != '0));
         if (nfdw_pkg::LANE_NEG[j]) begin
            w = sat_neg ? nfdw_pkg::WEIGHT_MIN : (WW'(0) - q_i[j]);
         end else begin
            w = sat_pos ? nfdw_pkg::WEIGHT_MAX : q_i[j];
         end
         if (ctl_i.bad) begin
            weight_in[j] = '0;
         end else if (ctl_i.row == nfdw_pkg::ROW_D0) begin
            weight_in[j] = (j == 0) ? nfdw_pkg::WEIGHT_ONE : '0;
         end else if (ctl_i.act[j]) begin
            weight_in[j] = w;
         end else begin
            weight_in[j] = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance_o) begin
         valid_ff <= ctl_i.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance_o) begin
         data_ff <= weight_in;
         user_ff <= {ctl_i.bad, ctl_i.row};
         last_ff <= ctl_i.last;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tuser  = user_ff;
   assign rsp_tlast  = last_ff;

endmodule

[rtl/nonuniform_fd_weights_unit.sv]
// ----------------------------------------------------------------------------
// nonuniform_fd_weights_unit
// lagrange derivative weights at the newest time of a non-uniform stencil
// ----------------------------------------------------------------------------
//   channel  direction  payload
//   req      in         time_0..time_3, signed q16.16
//   rsp      out        weight_0..3 q24.24 in tdata, order and error in tuser
//   csr      in         stencil_size, write only
//
// an item yields one weight row per stencil point (2 to 4); the row sequencer
// issues one derivative row a cycle into four divider lanes unless a held result stalls it.
// the path has 56 register stages: 5 front-end stages, 50 divider stages, output.
// reset clears only control state; there is no clearing pass.
// a held result stalls the row pipeline; the front end still buffers items.
module nonuniform_fd_weights_unit (
   input  logic          clock,
   input  logic          reset,
   input  logic          csr_wr_en,
   input  logic [2:0]    csr_wr_data,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [127:0]  req_tdata,   // time_0, time_1, time_2, time_3
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [191:0]  rsp_tdata,   // weight_0, weight_1, weight_2, weight_3
   output logic [2:0]    rsp_tuser,   // deriv_order, bad_times
   output logic          rsp_tlast    // last_row
);

   localparam int L = nfdw_pkg::LANES;

   logic [nfdw_pkg::SIZE_WIDTH-1:0] size_ff;
   logic                            item_valid;
   nfdw_pkg::item_type              item;
   logic                            advance;
   logic                            issue;
   logic                            last_row;
   logic [nfdw_pkg::ROW_WIDTH-1:0]  row_ff;
   logic [nfdw_pkg::ROW_WIDTH-1:0]  row_in;
   nfdw_pkg::ctl_type               ctl_in;
   nfdw_pkg::ctl_type               ctl_ff [0:nfdw_pkg::LANE_DEPTH-1];
   logic [nfdw_pkg::NUM1_WIDTH-1:0] num [L];
   logic [L-1:0][nfdw_pkg::QUO_BITS-1:0] lane_q;
   logic [L-1:0]                    lane_ovf;

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= nfdw_pkg::SIZE_RESET;
      end else if (csr_wr_en) begin
         size_ff <= csr_wr_data;
      end
   end

   nfdw_prep u_prep (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .times_i   (req_tdata),
      .size_i    (size_ff),
      .out_valid (item_valid),
      .out_item  (item),
      .out_take  (issue && last_row)
   );

   assign issue    = item_valid && advance;
   assign last_row = (row_ff == nfdw_pkg::ROW_WIDTH'(item.size - nfdw_pkg::SIZE_WIDTH'(1)));

   always_comb begin
      row_in = row_ff;
      if (issue) begin
         row_in = last_row ? nfdw_pkg::ROW_D0 : row_ff + nfdw_pkg::ROW_WIDTH'(1);
      end
      ctl_in.valid = item_valid;
      ctl_in.row   = row_ff;
      ctl_in.last  = last_row;
      ctl_in.bad   = item.bad;
      ctl_in.act   = item.act;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= nfdw_pkg::ROW_D0;
         for (int i = 0; i < nfdw_pkg::LANE_DEPTH; i++) begin
            ctl_ff[i] <= '0;
         end
      end else begin
         row_ff <= row_in;
         if (advance) begin
            ctl_ff[0] <= ctl_in;
            for (int i = 1; i < nfdw_pkg::LANE_DEPTH; i++) begin
               ctl_ff[i] <= ctl_ff[i-1];
            end
         end
      end
   end

   for (genvar j = 0; j < L; j++) begin : g_lane
      always_comb begin
         case (row_ff)
            nfdw_pkg::ROW_D1: num[j] = item.lane[j].n1;
            nfdw_pkg::ROW_D2: num[j] = nfdw_pkg::NUM1_WIDTH'(item.lane[j].n2);
            nfdw_pkg::ROW_D3: num[j] = nfdw_pkg::NUM1_WIDTH'(item.lane[j].n3);
            default:          num[j] = '0;
         endcase
      end

      nfdw_lane u_lane (
         .clock  (clock),
         .enable (advance),
         .den_i  (item.lane[j].den),
         .num_i  (num[j]),
         .row_i  (row_ff),
         .q_o    (lane_q[j]),
         .ovf_o  (lane_ovf[j])
      );
   end

   nfdw_merge u_merge (
      .clock      (clock),
      .reset      (reset),
      .ctl_i      (ctl_ff[nfdw_pkg::LANE_DEPTH-1]),
      .q_i        (lane_q),
      .ovf_i      (lane_ovf),
      .advance_o  (advance),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

[sim/nfdw_checker.sv]
// ----------------------------------------------------------------------------
// nfdw_checker
// watches the csr, req and rsp channels of the weight unit, predicts every
// weight row from the accepted stencil times and compares it on arrival
// ----------------------------------------------------------------------------
module nfdw_checker (
   input  logic          clock,
   input  logic          reset,
   input  logic          csr_wr_en,
   input  logic [2:0]    csr_wr_data,
   input  logic          req_tvalid,
   input  logic          req_tready,
   input  logic [127:0]  req_tdata,
   input  logic          rsp_tvalid,
   input  logic          rsp_tready,
   input  logic [191:0]  rsp_tdata,
   input  logic [2:0]    rsp_tuser,
   input  logic          rsp_tlast,
   output int            errors,
   output int            rows_pending,
   output int            rows_checked
);

   typedef struct packed {
      logic [191:0] weights;
      logic [2:0]   user;
      logic         last;
   } weight_row_type;

   weight_row_type row_q[$];
   logic [nfdw_pkg::SIZE_WIDTH-1:0] stencil_size;

   // round to nearest, ties away from zero, then saturate
   function automatic logic [nfdw_pkg::WEIGHT_WIDTH-1:0] lagrange_weight(
      bit neg, logic [255:0] num, logic [255:0] den, int k);
      logic [255:0] q;
      logic [255:0] cap;
      q = ((num << (nfdw_pkg::WEIGHT_FRAC + nfdw_pkg::TIME_FRAC * k + 1)) + den)
          / (den << 1);
      cap = 256'(1) << (nfdw_pkg::WEIGHT_WIDTH - 1);
      if (!neg) cap = cap - 1;
      if (q > cap) q = cap;
      return neg ? -q[nfdw_pkg::WEIGHT_WIDTH-1:0] : q[nfdw_pkg::WEIGHT_WIDTH-1:0];
   endfunction

   task automatic predict_rows(logic [127:0] times);
      logic [nfdw_pkg::WEIGHT_WIDTH-1:0] w [4][4];
      longint t [4];
      logic [255:0] a, b, c, bb, cc, e, d0, d1, d2, d3;
      int size;
      bit bad;
      weight_row_type row;
      size = stencil_size < 2 ? 2 : (stencil_size > 4 ? 4 : int'(stencil_size));
      bad = 0;
      for (int j = 0; j < 4; j++) begin
         t[j] = longint'($signed(times[32*j +: 32]));
         for (int r = 0; r < 4; r++) w[r][j] = '0;
      end
      for (int j = 1; j < size; j++)
         if (!(t[j-1] > t[j])) bad = 1;
      if (!bad) begin
         a = 256'(t[0] - t[1]);
         w[0][0] = lagrange_weight(0, 1, 1, 0);
         if (size == 2) begin
            w[1][0] = lagrange_weight(0, 1, a, 1);
            w[1][1] = lagrange_weight(1, 1, a, 1);
         end else if (size == 3) begin
            b = 256'(t[1] - t[2]);
            bb = a + b;
            w[1][0] = lagrange_weight(0, 2 * a + b, a * bb, 1);
            w[1][1] = lagrange_weight(1, bb, a * b, 1);
            w[1][2] = lagrange_weight(0, a, b * bb, 1);
            w[2][0] = lagrange_weight(0, 2, a * bb, 2);
            w[2][1] = lagrange_weight(1, 2, a * b, 2);
            w[2][2] = lagrange_weight(0, 2, b * bb, 2);
         end else begin
            b = 256'(t[1] - t[2]);
            c = 256'(t[2] - t[3]);
            bb = a + b;
            cc = bb + c;
            e = b + c;
            d0 = a * bb * cc;
            d1 = a * b * e;
            d2 = bb * b * c;
            d3 = cc * e * c;
            w[1][0] = lagrange_weight(0, bb * cc + a * cc + a * bb, d0, 1);
            w[1][1] = lagrange_weight(1, bb * cc, d1, 1);
            w[1][2] = lagrange_weight(0, a * cc, d2, 1);
            w[1][3] = lagrange_weight(1, a * bb, d3, 1);
            w[2][0] = lagrange_weight(0, 2 * (a + bb + cc), d0, 2);
            w[2][1] = lagrange_weight(1, 2 * (bb + cc), d1, 2);
            w[2][2] = lagrange_weight(0, 2 * (a + cc), d2, 2);
            w[2][3] = lagrange_weight(1, 2 * (a + bb), d3, 2);
            w[3][0] = lagrange_weight(0, 6, d0, 3);
            w[3][1] = lagrange_weight(1, 6, d1, 3);
            w[3][2] = lagrange_weight(0, 6, d2, 3);
            w[3][3] = lagrange_weight(1, 6, d3, 3);
         end
      end
      for (int r = 0; r < size; r++) begin
         row.weights = {w[r][3], w[r][2], w[r][1], w[r][0]};
         row.user = {bad, nfdw_pkg::ROW_WIDTH'(r)};
         row.last = (r == size - 1);
         row_q.push_back(row);
      end
   endtask

   task automatic report_mismatch(string what, logic [191:0] got, logic [191:0] want);
      errors++;
      $display("%0t mismatch %s: got %h want %h", $time, what, got, want);
   endtask

   task automatic check_row();
      weight_row_type want;
      if (row_q.size() == 0) begin
         report_mismatch("unexpected row", rsp_tdata, '0);
         return;
      end
      want = row_q.pop_front();
      rows_checked++;
      for (int j = 0; j < 4; j++)
         if (rsp_tdata[48*j +: 48] !== want.weights[48*j +: 48])
            report_mismatch($sformatf("weight_%0d", j), rsp_tdata[48*j +: 48],
                            want.weights[48*j +: 48]);
      if (rsp_tuser[1:0] !== want.user[1:0])
         report_mismatch("deriv_order", rsp_tuser[1:0], want.user[1:0]);
      if (rsp_tuser[2] !== want.user[2])
         report_mismatch("bad_times", rsp_tuser[2], want.user[2]);
      if (rsp_tlast !== want.last)
         report_mismatch("last_row", rsp_tlast, want.last);
   endtask

   initial begin
      errors = 0;
      rows_checked = 0;
      rows_pending = 0;
      stencil_size = nfdw_pkg::SIZE_RESET;
   end

   always @(posedge clock) begin
      if (reset) begin
         stencil_size = nfdw_pkg::SIZE_RESET;
      end else begin
         if (rsp_tvalid && rsp_tready) check_row();
         if (req_tvalid && req_tready) predict_rows(req_tdata);
         if (csr_wr_en) stencil_size = csr_wr_data;
      end
      rows_pending = row_q.size();
   end

endmodule

[sim/tb_nonuniform_fd_weights_unit.sv]
// ----------------------------------------------------------------------------
// tb_nonuniform_fd_weights_unit
// drives stencil times under every stencil size setting with varied idling
// and back-pressure; a checker beside the unit predicts and compares rows
// ----------------------------------------------------------------------------
module tb_nonuniform_fd_weights_unit;

   logic          clock = 0;
   logic          reset = 1;
   logic          csr_wr_en = 0;
   logic [2:0]    csr_wr_data = '0;
   logic          req_tvalid = 0;
   logic          req_tready;
   logic [127:0]  req_tdata = '0;
   logic          rsp_tvalid;
   logic          rsp_tready = 0;
   logic [191:0]  rsp_tdata;
   logic [2:0]    rsp_tuser;
   logic          rsp_tlast;
   int            errors, rows_pending, rows_checked;
   int            send_idle_pct = 0;
   int            recv_stall_pct = 0;
   bit            hold_go = 0;
   int            items_sent = 0;

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   nonuniform_fd_weights_unit DUT (
      .clock, .reset, .csr_wr_en, .csr_wr_data,
      .req_tvalid, .req_tready, .req_tdata,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tuser, .rsp_tlast
   );

   nfdw_checker CHK (
      .clock, .reset, .csr_wr_en, .csr_wr_data,
      .req_tvalid, .req_tready, .req_tdata,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tuser, .rsp_tlast,
      .errors, .rows_pending, .rows_checked
   );

   // receiver: random stalls, plus one long hold-off on request
   initial begin
      forever begin
         @(posedge clock);
         if (hold_go) begin
            rsp_tready <= 0;
            repeat (400) @(posedge clock);
            hold_go = 0;
         end
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   initial begin
      #5_000_000;
      $display("tb_nonuniform_fd_weights_unit: FAIL");
      $finish;
   end

   function automatic logic [127:0] stencil_times(longint t0, longint t1,
                                                  longint t2, longint t3);
      return {t3[31:0], t2[31:0], t1[31:0], t0[31:0]};
   endfunction

   task automatic send_times(logic [127:0] times);
      req_tdata <= times;
      req_tvalid <= 1;
      do @(posedge clock); while (!req_tready);
      items_sent++;
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   // mostly strictly decreasing times with gaps of widely varying magnitude
   task automatic send_random();
      longint t [4];
      t[0] = longint'($signed($urandom));
      if ($urandom_range(9) == 0) begin
         send_times({$urandom, $urandom, $urandom, $urandom});
      end else begin
         for (int j = 1; j < 4; j++)
            t[j] = t[j-1] - $urandom_range(1, 32'(1) << $urandom_range(0, 29));
         if (t[3] < -64'sd2147483648)
            for (int j = 0; j < 4; j++) t[j] = t[j] + 64'sd2147483647 - t[0];
         if ($urandom_range(14) == 0) t[$urandom_range(1, 3)] = t[0];
         send_times(stencil_times(t[0], t[1], t[2], t[3]));
      end
   endtask

   task automatic drain_and_write(logic [2:0] value);
      req_tvalid <= 0;
      @(posedge clock);
      while (rows_pending != 0) @(posedge clock);
      repeat (70) @(posedge clock);
      csr_wr_en <= 1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 0;
      @(posedge clock);
   endtask

   initial begin
      logic [2:0] sizes [8];
      sizes = '{nfdw_pkg::SIZE_FOUR, nfdw_pkg::SIZE_TWO, nfdw_pkg::SIZE_THREE,
                3'd0, 3'd7, 3'd1, 3'd5, 3'd6};
      repeat (9) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      for (int p = 0; p < 8; p++) begin
         drain_and_write(sizes[p]);
         send_idle_pct  = (p % 4 == 1 || p % 4 == 3) ? (p % 4 == 3 ? 19 : 49) : 0;
         recv_stall_pct = (p % 4 == 2 || p % 4 == 3) ? (p % 4 == 3 ? 19 : 49) : 0;
         // directed: even spacing, one-lsb gaps, full range, ties, reversals
         send_times(stencil_times(3 << 16, 2 << 16, 1 << 16, 0));
         send_times(stencil_times(1, 0, -1, -2));
         send_times(stencil_times(32'sh7fffffff, 32'sh7ffffffe, 0, -32'sh80000000));
         send_times(stencil_times(32'sh7fffffff, 0, -1, -32'sh80000000));
         send_times(stencil_times(5, 5, 3, 1));
         send_times(stencil_times(5, 4, 4, 1));
         send_times(stencil_times(5, 4, 3, 3));
         send_times(stencil_times(0, 1, 2, 3));
         send_times(stencil_times(-1, -2, 32'sh7fffffff, 32'sh7fffffff));
         send_times({32'hffffffff, 32'h0, 32'hffffffff, 32'h0});
         if (p == 2) hold_go = 1;
         repeat (p == 0 ? 15 : 5) send_random();
      end
      req_tvalid <= 0;
      @(posedge clock);
      while (rows_pending != 0) @(posedge clock);
      repeat (70) @(posedge clock);
      $display("sent %0d stencils over sizes 0..7 as written, %0d weight rows checked",
               items_sent, rows_checked);
      if (errors == 0)
         $display("tb_nonuniform_fd_weights_unit: PASS");
      else
         $display("tb_nonuniform_fd_weights_unit: FAIL");
      $finish;
   end

endmodule
